// ===== hdl/rbst_pkg.sv =====
// Shared constants, register indexes and payload types for the ray/box slab test.
package rbst_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int TAG_WIDTH   = 16;
	localparam int IDX_WIDTH   = 3;

	localparam logic [IDX_WIDTH-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [IDX_WIDTH-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [IDX_WIDTH-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [IDX_WIDTH-1:0] REG_DIR_X    = 3'd3;
	localparam logic [IDX_WIDTH-1:0] REG_DIR_Y    = 3'd4;
	localparam logic [IDX_WIDTH-1:0] REG_DIR_Z    = 3'd5;

	localparam logic [COORD_WIDTH-1:0] DIR_X_RESET = COORD_WIDTH'(65536);

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] center_x;
		logic signed [COORD_WIDTH-1:0] center_y;
		logic signed [COORD_WIDTH-1:0] center_z;
		logic [COORD_WIDTH-2:0]        half_x;
		logic [COORD_WIDTH-2:0]        half_y;
		logic [COORD_WIDTH-2:0]        half_z;
		logic [TAG_WIDTH-1:0]          box_tag;
	} box_t;

	typedef struct packed {
		logic                 hit;
		logic [TAG_WIDTH-1:0] result_tag;
	} result_t;

endpackage

// ===== hdl/ray_box_slab_test.sv =====
// Top level of the ray/box slab test: ray registers, three axis units, hit merge, output skid.
//
// Tests one axis-aligned box per cycle, while the skid entry is free, against the ray
// held in the configuration registers (origin and direction, signed Q16.16). The
// pipeline depth is set by the restoring divider cell chains, one quotient bit per
// cell, two chains per axis. A new box is taken every cycle unless the skid entry
// is occupied; a two-entry output buffer keeps the input open while one finished
// result waits. Write the ray only while no box is in flight.
module ray_box_slab_test (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rbst_pkg::IDX_WIDTH-1:0]      cfg_index,
	input  logic [rbst_pkg::COORD_WIDTH-1:0]    cfg_data,
	input  logic                                box_valid,
	output logic                                box_ready,
	input  rbst_pkg::box_t                      box,
	output logic                                result_valid,
	input  logic                                result_ready,
	output rbst_pkg::result_t                   result
);

	localparam int W   = rbst_pkg::COORD_WIDTH;
	localparam int NW  = W + 1 + rbst_pkg::FRAC_BITS;
	localparam int LAT = NW + 4;

	logic [W-1:0] origin_x_q, origin_y_q, origin_z_q;
	logic [W-1:0] dir_x_q, dir_y_q, dir_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			dir_x_q    <= rbst_pkg::DIR_X_RESET;
			dir_y_q    <= '0;
			dir_z_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rbst_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data;
				rbst_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_data;
				rbst_pkg::REG_ORIGIN_Z: origin_z_q <= cfg_data;
				rbst_pkg::REG_DIR_X:    dir_x_q    <= cfg_data;
				rbst_pkg::REG_DIR_Y:    dir_y_q    <= cfg_data;
				rbst_pkg::REG_DIR_Z:    dir_z_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic [LAT-1:0] vld_q;
	rbst_pkg::box_t box_s1;
	logic [rbst_pkg::TAG_WIDTH-1:0] tag_q [NW+2];

	assign box_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], box_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			box_s1   <= box;
			tag_q[0] <= box_s1.box_tag;
			for (int i = 1; i < NW + 2; i++) begin
				tag_q[i] <= tag_q[i-1];
			end
		end
	end

	logic signed [W-1:0] lx, hx, ly, hy, lz, hz;
	logic okx, oky, okz;

	rbst_axis #(.W(W), .FRAC(rbst_pkg::FRAC_BITS)) u_axis_x (
		.clk(clk), .en(en), .c(box_s1.center_x), .h(box_s1.half_x),
		.o(origin_x_q), .d(dir_x_q), .lo(lx), .hi(hx), .ok(okx)
	);
	rbst_axis #(.W(W), .FRAC(rbst_pkg::FRAC_BITS)) u_axis_y (
		.clk(clk), .en(en), .c(box_s1.center_y), .h(box_s1.half_y),
		.o(origin_y_q), .d(dir_y_q), .lo(ly), .hi(hy), .ok(oky)
	);
	rbst_axis #(.W(W), .FRAC(rbst_pkg::FRAC_BITS)) u_axis_z (
		.clk(clk), .en(en), .c(box_s1.center_z), .h(box_s1.half_z),
		.o(origin_z_q), .d(dir_z_q), .lo(lz), .hi(hz), .ok(okz)
	);

	logic signed [W-1:0] enter_xy, enter, leave_xy, leave;
	rbst_pkg::result_t res_s, skid_q;
	logic skid_vld_q;

	assign enter_xy = (ly > lx) ? ly : lx;
	assign enter    = (lz > enter_xy) ? lz : enter_xy;
	assign leave_xy = (hy < hx) ? hy : hx;
	assign leave    = (hz < leave_xy) ? hz : leave_xy;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s.hit        <= okx & oky & okz & (enter <= leave);
			res_s.result_tag <= tag_q[NW+1];
		end
	end

	// pipeline stalls only when the skid entry is occupied
	logic take, push;

	assign en   = !skid_vld_q;
	assign take = result_ready || !result_valid;
	assign push = en && vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			skid_vld_q   <= 1'b0;
		end else if (take) begin
			if (skid_vld_q) begin
				result_valid <= 1'b1;
				skid_vld_q   <= 1'b0;
			end else begin
				result_valid <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result <= skid_vld_q ? skid_q : res_s;
		end else if (push) begin
			skid_q <= res_s;
		end
	end

endmodule

// ===== hdl/rbst_div_cell.sv =====
// One restoring-division step: brings in one dividend bit, emits one quotient bit.
module rbst_div_cell #(
	parameter int W  = rbst_pkg::COORD_WIDTH,
	parameter int NW = rbst_pkg::COORD_WIDTH + 1 + rbst_pkg::FRAC_BITS
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  dm,
	input  logic [W-2:0]  rem_i,
	input  logic [NW-1:0] num_i,
	input  logic [W-1:0]  q_i,
	input  logic          big_i,
	output logic [W-2:0]  rem_o,
	output logic [NW-1:0] num_o,
	output logic [W-1:0]  q_o,
	output logic          big_o
);

	logic [W-1:0] part;
	logic [W-1:0] diff;
	logic         ge;

	assign part = {rem_i, num_i[NW-1]};
	assign ge   = (part >= dm);
	assign diff = part - dm;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[W-2:0] : part[W-2:0];
			num_o <= {num_i[NW-2:0], 1'b0};
			q_o   <= {q_i[W-2:0], ge};
			// quotient bits pushed out the top only matter for saturation
			big_o <= big_i | q_i[W-1];
		end
	end

endmodule

// ===== hdl/rbst_axis.sv =====
// One axis of the slab test: bound setup, two divider cell chains, saturate and order.
module rbst_axis #(
	parameter int W    = rbst_pkg::COORD_WIDTH,
	parameter int FRAC = rbst_pkg::FRAC_BITS
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] c,
	input  logic [W-2:0]        h,
	input  logic [W-1:0]        o,
	input  logic [W-1:0]        d,
	output logic signed [W-1:0] lo,
	output logic signed [W-1:0] hi,
	output logic                ok
);

	localparam int NW = W + 1 + FRAC;

	logic [W+1:0] ce, he, oe, nmin, nmax, mmin, mmax;
	logic [W-1:0] dm_q;

	// bounds relative to the origin, exact in W+2 bits
	assign ce   = {{2{c[W-1]}}, c};
	assign he   = {3'b000, h};
	assign oe   = {{2{o[W-1]}}, o};
	assign nmin = ce - he - oe;
	assign nmax = ce + he - oe;
	assign mmin = nmin[W+1] ? (~nmin + 1'b1) : nmin;
	assign mmax = nmax[W+1] ? (~nmax + 1'b1) : nmax;

	// the user must keep the direction static while boxes are in flight; not enforced here
	always_ff @(posedge clk) begin
		dm_q <= d[W-1] ? (~d + 1'b1) : d;
	end

	logic [W-2:0]  rem_a [NW+1];
	logic [NW-1:0] num_a [NW+1];
	logic [W-1:0]  q_a   [NW+1];
	logic          big_a [NW+1];
	logic [W-2:0]  rem_b [NW+1];
	logic [NW-1:0] num_b [NW+1];
	logic [W-1:0]  q_b   [NW+1];
	logic          big_b [NW+1];
	logic [2:0]    sb_s1;
	logic [2:0]    sb_q  [NW];

	always_ff @(posedge clk) begin
		if (en) begin
			num_a[0] <= {mmin[W:0], {FRAC{1'b0}}};
			num_b[0] <= {mmax[W:0], {FRAC{1'b0}}};
			// {neg of min quotient, neg of max quotient, origin inside slab}
			sb_s1    <= {nmin[W+1] ^ d[W-1], nmax[W+1] ^ d[W-1],
				(nmin[W+1] || (nmin == '0)) && !nmax[W+1]};
			sb_q[0]  <= sb_s1;
			for (int i = 1; i < NW; i++) begin
				sb_q[i] <= sb_q[i-1];
			end
		end
	end

	assign rem_a[0] = '0;
	assign q_a[0]   = '0;
	assign big_a[0] = 1'b0;
	assign rem_b[0] = '0;
	assign q_b[0]   = '0;
	assign big_b[0] = 1'b0;

	for (genvar k = 0; k < NW; k++) begin : g_cell
		rbst_div_cell #(.W(W), .NW(NW)) u_min (
			.clk(clk), .en(en), .dm(dm_q),
			.rem_i(rem_a[k]), .num_i(num_a[k]), .q_i(q_a[k]), .big_i(big_a[k]),
			.rem_o(rem_a[k+1]), .num_o(num_a[k+1]), .q_o(q_a[k+1]), .big_o(big_a[k+1])
		);
		rbst_div_cell #(.W(W), .NW(NW)) u_max (
			.clk(clk), .en(en), .dm(dm_q),
			.rem_i(rem_b[k]), .num_i(num_b[k]), .q_i(q_b[k]), .big_i(big_b[k]),
			.rem_o(rem_b[k+1]), .num_o(num_b[k+1]), .q_o(q_b[k+1]), .big_o(big_b[k+1])
		);
	end

	function automatic logic [W-1:0] sat(input logic [W-1:0] q, input logic big,
		input logic neg);
		logic [W-1:0] lim;
		logic [W-1:0] m;
		lim = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		m   = (big || (q > lim)) ? lim : q;
		return neg ? (~m + 1'b1) : m;
	endfunction

	logic signed [W-1:0] ta, tb;
	logic                dzero;

	assign ta    = sat(q_a[NW], big_a[NW], sb_q[NW-1][2]);
	assign tb    = sat(q_b[NW], big_b[NW], sb_q[NW-1][1]);
	assign dzero = (d == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			if (dzero) begin
				lo <= {1'b1, {(W-1){1'b0}}};
				hi <= {1'b0, {(W-1){1'b1}}};
				ok <= sb_q[NW-1][0];
			end else begin
				lo <= (ta > tb) ? tb : ta;
				hi <= (ta > tb) ? ta : tb;
				ok <= 1'b1;
			end
		end
	end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the ray/box slab test block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = rbst_pkg::COORD_WIDTH + 21;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [rbst_pkg::IDX_WIDTH-1:0] cfg_index;
	logic [rbst_pkg::COORD_WIDTH-1:0] cfg_data;
	logic box_valid;
	logic box_ready;
	rbst_pkg::box_t box;
	logic result_valid;
	logic result_ready;
	rbst_pkg::result_t result;

	ray_box_slab_test dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .box_valid(box_valid), .box_ready(box_ready), .box(box),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	// ray as seen by the predictor
	logic signed [rbst_pkg::COORD_WIDTH-1:0] ray_org [3];
	logic signed [rbst_pkg::COORD_WIDTH-1:0] ray_dir [3];

	rbst_pkg::box_t pending_boxes [$];
	rbst_pkg::result_t expected_hits [$];
	int error_count;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_send;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Q16.16 slab parameter, truncated toward zero, saturated to COORD_WIDTH bits
	function automatic logic signed [95:0] slab_param(logic signed [95:0] num,
			logic signed [rbst_pkg::COORD_WIDTH-1:0] d);
		logic signed [95:0] q;
		logic signed [95:0] tmax;
		logic signed [95:0] tmin;
		tmax = (96'sd1 <<< (rbst_pkg::COORD_WIDTH - 1)) - 96'sd1;
		tmin = -(96'sd1 <<< (rbst_pkg::COORD_WIDTH - 1));
		q = (num <<< rbst_pkg::FRAC_BITS) / 96'(d);
		if (q > tmax) q = tmax;
		if (q < tmin) q = tmin;
		return q;
	endfunction

	function automatic rbst_pkg::result_t predict_hit(rbst_pkg::box_t b);
		rbst_pkg::result_t r;
		logic signed [95:0] c [3];
		logic signed [95:0] h [3];
		logic signed [95:0] lo, hi, a, bq, enter, leave;
		bit ok;
		c[0] = 96'(b.center_x); c[1] = 96'(b.center_y); c[2] = 96'(b.center_z);
		h[0] = 96'({1'b0, b.half_x}); h[1] = 96'({1'b0, b.half_y});
		h[2] = 96'({1'b0, b.half_z});
		ok = 1'b1;
		enter = -(96'sd1 <<< (rbst_pkg::COORD_WIDTH - 1));
		leave = (96'sd1 <<< (rbst_pkg::COORD_WIDTH - 1)) - 96'sd1;
		for (int k = 0; k < 3; k++) begin
			lo = c[k] - h[k] - 96'(ray_org[k]);
			hi = c[k] + h[k] - 96'(ray_org[k]);
			if (ray_dir[k] == 0) begin
				if (!(lo <= 0 && hi >= 0)) ok = 1'b0;
			end else begin
				a = slab_param(lo, ray_dir[k]);
				bq = slab_param(hi, ray_dir[k]);
				if (a > bq) begin
					lo = a; a = bq; bq = lo;
				end
				if (a > enter) enter = a;
				if (bq < leave) leave = bq;
			end
		end
		r.hit = ok && (enter <= leave);
		r.result_tag = b.box_tag;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_valid <= 1'b0;
			result_ready <= 1'b0;
		end else begin
			if (!box_valid || box_ready) begin
				if (!hold_send && pending_boxes.size() > 0 &&
						$urandom_range(99) >= send_idle_pct) begin
					box <= pending_boxes[0];
					expected_hits = {expected_hits, predict_hit(pending_boxes[0])};
					void'(pending_boxes.pop_front());
					box_valid <= 1'b1;
				end else begin
					box_valid <= 1'b0;
				end
			end
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((box_valid && box_ready) || (result_valid && result_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("ray_box_slab_test regression: fail");
				$finish;
			end
			if (result_valid && result_ready) begin
				if (expected_hits.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					if (result.hit !== expected_hits[0].hit)
						report_mismatch($sformatf("hit %b expected %b, tag %h",
							result.hit, expected_hits[0].hit, expected_hits[0].result_tag));
					if (result.result_tag !== expected_hits[0].result_tag)
						report_mismatch($sformatf("tag %h expected %h",
							result.result_tag, expected_hits[0].result_tag));
					void'(expected_hits.pop_front());
				end
			end
		end
	end

	task automatic drain();
		while (pending_boxes.size() > 0 || box_valid || expected_hits.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_ray(logic [rbst_pkg::IDX_WIDTH-1:0] idx,
			logic [rbst_pkg::COORD_WIDTH-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		if (idx < rbst_pkg::REG_DIR_X)
			ray_org[2'(idx)] = v;
		else
			ray_dir[2'(idx - rbst_pkg::REG_DIR_X)] = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [rbst_pkg::COORD_WIDTH-1:0] pick_coord();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return $urandom;
			default: return 32'($signed($urandom_range(40 << 16)) - (20 << 16));
		endcase
	endfunction

	function automatic logic [rbst_pkg::COORD_WIDTH-2:0] pick_half();
		case ($urandom_range(4))
			0: return '1;
			1: return '0;
			2: return (rbst_pkg::COORD_WIDTH-1)'($urandom);
			default: return (rbst_pkg::COORD_WIDTH-1)'($urandom_range(8 << 16));
		endcase
	endfunction

	function automatic rbst_pkg::box_t random_box();
		rbst_pkg::box_t b;
		b.center_x = pick_coord(); b.center_y = pick_coord(); b.center_z = pick_coord();
		b.half_x = pick_half(); b.half_y = pick_half(); b.half_z = pick_half();
		b.box_tag = 16'($urandom);
		return b;
	endfunction

	function automatic logic [rbst_pkg::COORD_WIDTH-1:0] pick_dir();
		case ($urandom_range(6))
			0: return '0;
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			3: return 32'd1;
			4: return $urandom;
			default: return 32'($signed($urandom_range(4 << 16)) - (2 << 16));
		endcase
	endfunction

	task automatic random_ray();
		write_ray(rbst_pkg::REG_ORIGIN_X, pick_coord());
		write_ray(rbst_pkg::REG_ORIGIN_Y, pick_coord());
		write_ray(rbst_pkg::REG_ORIGIN_Z, pick_coord());
		write_ray(rbst_pkg::REG_DIR_X, pick_dir());
		write_ray(rbst_pkg::REG_DIR_Y, pick_dir());
		write_ray(rbst_pkg::REG_DIR_Z, pick_dir());
	endtask

	initial begin
		rbst_pkg::box_t b;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		box = '0;
		error_count = 0;
		quiet_cycles = 0;
		hold_send = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		ray_org[0] = 0; ray_org[1] = 0; ray_org[2] = 0;
		ray_dir[0] = rbst_pkg::DIR_X_RESET; ray_dir[1] = 0; ray_dir[2] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset ray (+x axis line)
		b = '0; b.box_tag = 16'h0001; pending_boxes = {pending_boxes, b};
		b.center_y = 32'sd65536; b.half_y = 31'd65536; b.box_tag = 16'h0002;
		pending_boxes = {pending_boxes, b};               // touching bound on zero-dir axis
		b.center_y = 32'sd65537; b.box_tag = 16'h0003; pending_boxes = {pending_boxes, b};
		b = '0; b.center_x = 32'h8000_0000; b.center_y = 32'h7fff_ffff;
		b.half_x = '1; b.half_y = '1; b.half_z = '1; b.box_tag = 16'hffff;
		pending_boxes = {pending_boxes, b};
		b.center_x = 32'h7fff_ffff; b.center_z = 32'h8000_0000; b.box_tag = 16'h0005;
		pending_boxes = {pending_boxes, b};
		drain();

		// diagonal ray: touching intervals, saturation with tiny direction
		write_ray(rbst_pkg::REG_DIR_Y, 32'sd65536);
		b = '0; b.center_x = 32'sd131072; b.half_x = 31'd65536;
		b.center_y = 32'sd0; b.half_y = 31'd65536; b.box_tag = 16'h0010;
		pending_boxes = {pending_boxes, b};               // x in [1,3], y in [-1,1] touch at 1
		b.center_y = -32'sd65537; b.box_tag = 16'h0011; pending_boxes = {pending_boxes, b};
		drain();
		write_ray(rbst_pkg::REG_DIR_X, 32'sd1);
		write_ray(rbst_pkg::REG_DIR_Y, -32'sd1);
		write_ray(rbst_pkg::REG_DIR_Z, 32'h8000_0000);
		write_ray(rbst_pkg::REG_ORIGIN_X, 32'h7fff_ffff);
		write_ray(rbst_pkg::REG_ORIGIN_Y, 32'h8000_0000);
		write_ray(rbst_pkg::REG_ORIGIN_Z, 32'sd12345);
		for (int i = 0; i < 10; i++) pending_boxes = {pending_boxes, random_box()};
		drain();

		// random phases, each with its own idling mix and a new ray for every batch
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 67 : 0;
			recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 16 : 0;
			for (int r = 0; r < 6; r++) begin
				random_ray();
				for (int i = 0; i < 72; i++) pending_boxes = {pending_boxes, random_box()};
				if (r == 3) begin
					// hold off until everything is back, then resume
					while (pending_boxes.size() > 36) @(posedge clk);
					hold_send = 1'b1;
					while (box_valid || expected_hits.size() > 0) @(posedge clk);
					hold_send = 1'b0;
				end
				drain();
			end
		end

		if (error_count == 0)
			$display("ray_box_slab_test regression: pass");
		else
			$display("ray_box_slab_test regression: fail");
		$finish;
	end

endmodule

// ===== ray_box_slab_test.f =====
hdl/rbst_pkg.sv
hdl/rbst_div_cell.sv
hdl/rbst_axis.sv
hdl/ray_box_slab_test.sv
tb/tb.sv
